[rtl/tmps_pkg.sv]
`default_nettype none

package tmps_pkg;

    localparam int DEF_MAX_N = 64;
    localparam int IDX_W     = 6;
    localparam int ELEM_W    = 16;
    localparam int AB_W      = 40;
    localparam int R_W       = 64;
    localparam int PROD_W    = AB_W + ELEM_W;
    localparam int N_W       = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [N_W-1:0] N_RESET    = 7'd64;
    localparam logic           REG_N_USED = 1'b0;

    typedef enum logic [1:0] {
        OP_WR_A    = 2'd0,
        OP_WR_B    = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_RD_R    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] element;
    } cmd_item_t;

    typedef struct packed {
        logic signed [R_W-1:0] result_value;
        logic                  address_error;
    } rsp_item_t;

    // P1: A*B, BB: Bt*Bt term, ABA: AB*At term
    typedef enum logic [1:0] {
        MAC_P1  = 2'd0,
        MAC_BB  = 2'd1,
        MAC_ABA = 2'd2
    } mac_kind_t;

    typedef struct packed {
        logic             valid;
        mac_kind_t        kind;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } mac_cmd_t;

    typedef struct packed {
        logic     wr_a;
        logic     wr_b;
        logic     rd_r;
        logic     load_rsp;
        logic     rsp_from_ram;
        logic     rsp_err;
        logic     set_rvalid;
        mac_cmd_t mac;
    } ctl_t;

    typedef struct packed {
        logic             idx_ok;
        logic             rvalid;
        logic             rsp_free;
        logic [IDX_W-1:0] nm1;
    } stat_t;

endpackage

`default_nettype wire

[rtl/tmps_ram.sv]
`default_nettype none

module tmps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tmps_ctrl.sv]
`default_nettype none

module tmps_ctrl #(
    parameter int MAX_N = tmps_pkg::DEF_MAX_N
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire tmps_pkg::op_t cmd_op,
    output logic               cmd_stall,
    input  wire tmps_pkg::stat_t stat,
    output tmps_pkg::ctl_t     ctl
);
    import tmps_pkg::*;

    localparam int IW = $clog2(MAX_N);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_P1,
        ST_DRAIN_P1,
        ST_BB,
        ST_ABA,
        ST_DRAIN_R,
        ST_PUSH
    } state_t;

    state_t         state_reg, state_next;
    logic [IW-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic           drn_reg, drn_next;
    logic           pend_err_reg, pend_err_next;
    logic           pend_rd_reg, pend_rd_next;
    logic [IW-1:0]  nm1;
    logic           acc;

    assign nm1       = stat.nm1[IW-1:0];
    assign cmd_stall = (state_reg != ST_IDLE);
    assign acc       = cmd_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        drn_next      = drn_reg;
        pend_err_next = pend_err_reg;
        pend_rd_next  = pend_rd_reg;

        ctl = '0;
        ctl.mac.kind = MAC_P1;
        ctl.mac.i    = IDX_W'(i_reg);
        ctl.mac.j    = IDX_W'(j_reg);
        ctl.mac.k    = IDX_W'(k_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd_op)
                        OP_WR_A, OP_WR_B:
                        begin
                            ctl.wr_a = (cmd_op == OP_WR_A) && stat.idx_ok;
                            ctl.wr_b = (cmd_op == OP_WR_B) && stat.idx_ok;
                            if (stat.rsp_free)
                            begin
                                ctl.load_rsp = 1'b1;
                                ctl.rsp_err  = !stat.idx_ok;
                            end
                            else
                            begin
                                pend_err_next = !stat.idx_ok;
                                pend_rd_next  = 1'b0;
                                state_next    = ST_PUSH;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_P1;
                        end
                        default:
                        begin
                            if (stat.idx_ok && stat.rvalid)
                            begin
                                ctl.rd_r   = 1'b1;
                                state_next = ST_RD_WAIT;
                            end
                            else if (stat.rsp_free)
                            begin
                                ctl.load_rsp = 1'b1;
                                ctl.rsp_err  = 1'b1;
                            end
                            else
                            begin
                                pend_err_next = 1'b1;
                                pend_rd_next  = 1'b0;
                                state_next    = ST_PUSH;
                            end
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                pend_err_next = 1'b0;
                pend_rd_next  = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_P1:
            begin
                ctl.mac.valid = 1'b1;
                ctl.mac.kind  = MAC_P1;
                ctl.mac.first = (k_reg == i_reg);
                ctl.mac.last  = (k_reg == nm1);
                if (k_reg == nm1)
                begin
                    if (j_reg == nm1)
                    begin
                        if (i_reg == nm1)
                        begin
                            drn_next   = 1'b0;
                            state_next = ST_DRAIN_P1;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = '0;
                            k_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        k_next = i_reg;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN_P1:
            begin
                // wait for the last AB write to pass s1_reg and s2_reg
                drn_next = 1'b1;
                if (drn_reg)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_BB;
                end
            end
            ST_BB:
            begin
                ctl.mac.valid = 1'b1;
                ctl.mac.kind  = MAC_BB;
                ctl.mac.first = (k_reg == '0);
                if (k_reg == nm1)
                begin
                    k_next     = j_reg;
                    state_next = ST_ABA;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_ABA:
            begin
                ctl.mac.valid = 1'b1;
                ctl.mac.kind  = MAC_ABA;
                ctl.mac.last  = (k_reg == nm1);
                if (k_reg == nm1)
                begin
                    k_next     = '0;
                    state_next = ST_BB;
                    if (j_reg == nm1)
                    begin
                        j_next = '0;
                        if (i_reg == nm1)
                        begin
                            drn_next   = 1'b0;
                            state_next = ST_DRAIN_R;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN_R:
            begin
                drn_next = 1'b1;
                if (drn_reg)
                begin
                    ctl.set_rvalid = 1'b1;
                    pend_err_next  = 1'b0;
                    pend_rd_next   = 1'b0;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (stat.rsp_free)
                begin
                    ctl.load_rsp     = 1'b1;
                    ctl.rsp_err      = pend_err_reg;
                    ctl.rsp_from_ram = pend_rd_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            drn_reg      <= 1'b0;
            pend_err_reg <= 1'b0;
            pend_rd_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            drn_reg      <= drn_next;
            pend_err_reg <= pend_err_next;
            pend_rd_reg  <= pend_rd_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tmps_dpath.sv]
`default_nettype none

module tmps_dpath #(
    parameter int MAX_N = tmps_pkg::DEF_MAX_N
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tmps_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [tmps_pkg::PDATA_W-1:0]     pwdata,
    output logic      [tmps_pkg::PDATA_W-1:0]     prdata,
    input  wire tmps_pkg::cmd_item_t              cmd,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output tmps_pkg::rsp_item_t                   rsp,
    input  wire tmps_pkg::ctl_t                   ctl,
    output tmps_pkg::stat_t                       stat
);
    import tmps_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]  MN_A  = AW'(MAX_N);
    localparam logic [N_W-1:0] MN_N  = N_W'(MAX_N);

    logic [N_W-1:0] n_reg;
    logic [N_W-1:0] n_eff;
    logic           rvalid_reg;
    logic           cfg_wr;

    logic [AW-1:0]  a_raddr, b0_raddr, b1_raddr, ab_raddr, cmd_addr;
    logic [ELEM_W-1:0] a_rd, b0_rd, b1_rd;
    logic [AB_W-1:0]   ab_rd;
    logic [R_W-1:0]    r_rd;

    mac_cmd_t s1_reg, s2_reg;
    logic signed [AB_W-1:0]   op_a;
    logic signed [ELEM_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [R_W-1:0]    prod_ext, term, sum, acc_reg;
    logic [AW-1:0]            wb_addr;

    logic                     rsp_valid_reg;
    rsp_item_t                rsp_reg;

    // configuration
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_N_USED);
    assign prdata = (paddr[2] == REG_N_USED) ? PDATA_W'(n_reg) : '0;

    always_comb
    begin
        if (n_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (n_reg > MN_N)
        begin
            n_eff = MN_N;
        end
        else
        begin
            n_eff = n_reg;
        end
    end

    assign stat.idx_ok   = ({1'b0, cmd.row} < n_eff) && ({1'b0, cmd.col} < n_eff);
    assign stat.rvalid   = rvalid_reg;
    assign stat.rsp_free = !rsp_valid_reg || !rsp_stall;
    assign stat.nm1      = IDX_W'(n_eff - 1'b1);

    assign cmd_addr = AW'(cmd.row) * MN_A + AW'(cmd.col);

    // read address select per pass
    always_comb
    begin
        a_raddr  = AW'(ctl.mac.i) * MN_A + AW'(ctl.mac.k);
        b0_raddr = AW'(ctl.mac.k) * MN_A + AW'(ctl.mac.j);
        b1_raddr = AW'(ctl.mac.j) * MN_A + AW'(ctl.mac.k);
        ab_raddr = AW'(ctl.mac.i) * MN_A + AW'(ctl.mac.k);
        case (ctl.mac.kind)
            MAC_BB:
            begin
                b0_raddr = AW'(ctl.mac.k) * MN_A + AW'(ctl.mac.i);
            end
            MAC_ABA:
            begin
                a_raddr = AW'(ctl.mac.j) * MN_A + AW'(ctl.mac.k);
            end
            default:
            begin
            end
        endcase
    end

    tmps_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .clk(clk), .we(ctl.wr_a), .waddr(cmd_addr), .wdata(cmd.element),
        .re(ctl.mac.valid), .raddr(a_raddr), .rdata(a_rd)
    );

    // two copies of B give two reads per cycle
    tmps_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b0_ram (
        .clk(clk), .we(ctl.wr_b), .waddr(cmd_addr), .wdata(cmd.element),
        .re(ctl.mac.valid), .raddr(b0_raddr), .rdata(b0_rd)
    );

    tmps_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b1_ram (
        .clk(clk), .we(ctl.wr_b), .waddr(cmd_addr), .wdata(cmd.element),
        .re(ctl.mac.valid), .raddr(b1_raddr), .rdata(b1_rd)
    );

    assign wb_addr = AW'(s2_reg.i) * MN_A + AW'(s2_reg.j);

    tmps_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_ab_ram (
        .clk(clk),
        .we(s2_reg.valid && s2_reg.last && (s2_reg.kind == MAC_P1)),
        .waddr(wb_addr), .wdata(sum[AB_W-1:0]),
        .re(ctl.mac.valid), .raddr(ab_raddr), .rdata(ab_rd)
    );

    tmps_ram #(.WIDTH(R_W), .DEPTH(DEPTH)) u_r_ram (
        .clk(clk),
        .we(s2_reg.valid && s2_reg.last && (s2_reg.kind != MAC_P1)),
        .waddr(wb_addr), .wdata(sum),
        .re(ctl.rd_r), .raddr(cmd_addr), .rdata(r_rd)
    );

    // stage 1: operand select and multiply
    always_comb
    begin
        case (s1_reg.kind)
            MAC_BB:
            begin
                op_a = AB_W'($signed(b0_rd));
                op_b = $signed(b1_rd);
            end
            MAC_ABA:
            begin
                op_a = $signed(ab_rd);
                op_b = $signed(a_rd);
            end
            default:
            begin
                op_a = AB_W'($signed(a_rd));
                op_b = $signed(b0_rd);
            end
        endcase
    end

    // stage 2: accumulate; Bt*Bt terms move up 8 fraction bits.
    // Sums stay below 2^58, so the 64-bit sum never overflows.
    assign prod_ext = R_W'(prod_reg);
    assign term     = (s2_reg.kind == MAC_BB) ? (prod_ext <<< 8) : prod_ext;
    assign sum      = s2_reg.first ? term : acc_reg + term;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (s2_reg.valid)
        begin
            acc_reg <= sum;
        end
        if (ctl.load_rsp)
        begin
            rsp_reg.result_value  <= ctl.rsp_from_ram ? $signed(r_rd) : '0;
            rsp_reg.address_error <= ctl.rsp_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= N_RESET;
            rvalid_reg    <= 1'b0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                n_reg      <= pwdata[N_W-1:0];
                rvalid_reg <= 1'b0;
            end
            else if (ctl.set_rvalid)
            begin
                rvalid_reg <= 1'b1;
            end
            s1_reg <= ctl.mac;
            s2_reg <= s1_reg;
            if (ctl.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/triangular_matrix_product_sum.sv]
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------
// cmd      | in        | cmd_valid/cmd_stall | op, row, col, element
// rsp      | out       | rsp_valid/rsp_stall | result_value, address_error
// APB      | in        | psel/penable/pready | n_used at byte address 0
//
// A/B writes respond from idle when the rsp slot is free; reads of R pass
// through ST_RD_WAIT and ST_PUSH. Compute runs on the one shared 40x16
// multiply-accumulate unit, which does one product per cycle.
// Reset clears the FSM, n_used (to 64) and the results-valid flag; matrix
// memories are not cleared. cmd_stall is high whenever the controller is
// not idle; a stalled rsp transaction holds, and one more can wait inside.
module triangular_matrix_product_sum #(
    parameter int MAX_N = tmps_pkg::DEF_MAX_N
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tmps_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tmps_pkg::PDATA_W-1:0] pwdata,
    output logic      [tmps_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire tmps_pkg::cmd_item_t          cmd,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output tmps_pkg::rsp_item_t               rsp
);
    import tmps_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    assign pready = 1'b1;

    // sequencer: accepts transactions and steps the i/j/k loops
    tmps_ctrl #(.MAX_N(MAX_N)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_op(cmd.op), .cmd_stall(cmd_stall),
        .stat(stat), .ctl(ctl)
    );

    // memories, MAC pipeline, n_used register and response register
    tmps_dpath #(.MAX_N(MAX_N)) u_dpath (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .ctl(ctl), .stat(stat)
    );

`ifndef SYNTH
    // a compute transaction keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.op == OP_COMPUTE) |=> cmd_stall)
        else $error("compute did not start");

    // matrix writes never overlap the MAC sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_a || ctl.wr_b) |-> !ctl.mac.valid)
        else $error("matrix write during compute");

    // a response is loaded only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_rsp |-> (!rsp_valid || !rsp_stall))
        else $error("response overwritten");
`endif

endmodule

`default_nettype wire
